/* rtl/hampel_pkg.sv */
// Shared types and constants of the three-tap Hampel outlier filter.
package hampel_pkg;

  // Number of accelerometer axes handled side by side.
  localparam int unsigned AXES = 3;

  // Sample and scale widths.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned FRAC_W   = 8;

  // Width of the threshold product and of the shifted deviation.
  localparam int unsigned PROD_W = SAMPLE_W + SCALE_W;

  // Reset value of the Q8.8 threshold scale, close to 10 * 1.4826.
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd3795;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [SAMPLE_W-1:0] mag_t;
  typedef logic        [SCALE_W-1:0]  scale_t;
  typedef logic        [PROD_W-1:0]   prod_t;

  typedef sample_t sample_vec_t [AXES];

endpackage

/* rtl/hampel_outlier_filter_3tap.sv */
// Top level of the three-tap Hampel outlier filter for three-axis samples.

// One item enters per clock cycle when the result side keeps up. An accepted
// item first waits in an input register, then the window logic (median,
// deviation median, one 16 x 16 multiply and compare per axis) updates the
// delay lines and loads the result register, from which its result shows.
// The first 2*TAP_SPACING items only fill the delay lines and give no result;
// every later item gives exactly one. The delay lines update straight from
// the window logic, as each update must see the corrected middle sample of
// the item before; this sets the rate of one item per cycle.
module hampel_outlier_filter_3tap
  import hampel_pkg::*;
#(
  parameter int unsigned TAP_SPACING = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [SCALE_W-1:0]  cfg_data_i,
  // Input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  accel_x_i,
  input  logic signed [15:0]  accel_y_i,
  input  logic signed [15:0]  accel_z_i,
  // Result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  filtered_x_o,
  output logic signed [15:0]  filtered_y_o,
  output logic signed [15:0]  filtered_z_o,
  output logic                outlier_x_o,
  output logic                outlier_y_o,
  output logic                outlier_z_o
);

  localparam int unsigned LINE_LEN = 2 * TAP_SPACING;
  localparam int unsigned CNT_W    = $clog2(LINE_LEN + 1);

  // Signed three-way median.
  function automatic sample_t med3s(sample_t a, sample_t b, sample_t c);
    sample_t lo;
    sample_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      return lo;
    end else if (c >= hi) begin
      return hi;
    end
    return c;
  endfunction

  // Unsigned three-way median.
  function automatic mag_t med3u(mag_t a, mag_t b, mag_t c);
    mag_t lo;
    mag_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      return lo;
    end else if (c >= hi) begin
      return hi;
    end
    return c;
  endfunction

  // Absolute difference of two signed samples; always fits in 16 bits.
  function automatic mag_t absdiff(sample_t x, sample_t y);
    logic signed [SAMPLE_W:0] d;
    d = (x >= y) ? ({x[SAMPLE_W-1], x} - {y[SAMPLE_W-1], y})
                 : ({y[SAMPLE_W-1], y} - {x[SAMPLE_W-1], x});
    return d[SAMPLE_W-1:0];
  endfunction

  // Threshold scale register; writes are always taken.
  scale_t scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_valid_i) begin
      scale_q <= cfg_data_i;
    end
  end

  // Input register and flow control.
  logic        in_valid_q;
  sample_vec_t in_data_q;
  logic        out_valid_q;
  logic [CNT_W-1:0] fill_q;
  logic        emit;
  logic        advance;

  assign emit       = (fill_q == CNT_W'(LINE_LEN));
  assign advance    = in_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q[0] <= accel_x_i;
      in_data_q[1] <= accel_y_i;
      in_data_q[2] <= accel_z_i;
    end
  end

  // Fill count saturates once the delay lines hold a full window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (advance && !emit) begin
      fill_q <= fill_q + CNT_W'(1);
    end
  end

  // Per-axis delay lines, oldest sample at index zero.
  sample_t line_q [AXES][LINE_LEN];

  // Window evaluation for each axis.
  sample_t med    [AXES];
  mag_t    dev    [AXES];
  mag_t    mad    [AXES];
  prod_t   thresh [AXES];
  prod_t   lhs    [AXES];
  logic    outl   [AXES];
  sample_t mid    [AXES];

  always_comb begin
    for (int ax = 0; ax < AXES; ax++) begin
      med[ax]    = med3s(line_q[ax][0], line_q[ax][TAP_SPACING], in_data_q[ax]);
      dev[ax]    = absdiff(line_q[ax][TAP_SPACING], med[ax]);
      mad[ax]    = med3u(absdiff(line_q[ax][0], med[ax]), dev[ax],
                         absdiff(in_data_q[ax], med[ax]));
      thresh[ax] = PROD_W'(mad[ax]) * PROD_W'(scale_q);
      lhs[ax]    = PROD_W'(dev[ax]) << FRAC_W;
      outl[ax]   = (lhs[ax] > thresh[ax]);
      mid[ax]    = outl[ax] ? med[ax] : line_q[ax][TAP_SPACING];
    end
  end

  // Delay line shift; the corrected middle sample moves on with the line.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int ax = 0; ax < AXES; ax++) begin
        for (int k = 0; k < LINE_LEN - 1; k++) begin
          if ((k + 1 == TAP_SPACING) && emit) begin
            line_q[ax][k] <= mid[ax];
          end else begin
            line_q[ax][k] <= line_q[ax][k + 1];
          end
        end
        line_q[ax][LINE_LEN-1] <= in_data_q[ax];
      end
    end
  end

  // Result register.
  sample_t res_data_q [AXES];
  logic    res_flag_q [AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      for (int ax = 0; ax < AXES; ax++) begin
        res_data_q[ax] <= mid[ax];
        res_flag_q[ax] <= outl[ax];
      end
    end
  end

  // Result ports.
  assign out_valid_o  = out_valid_q;
  assign filtered_x_o = res_data_q[0];
  assign filtered_y_o = res_data_q[1];
  assign filtered_z_o = res_data_q[2];
  assign outlier_x_o  = res_flag_q[0];
  assign outlier_y_o  = res_flag_q[1];
  assign outlier_z_o  = res_flag_q[2];

endmodule

/* bench/tb_hampel_outlier_filter_3tap.sv */
// Self-checking testbench for the three-tap Hampel outlier filter.
`timescale 1ns / 100ps

module tb_hampel_outlier_filter_3tap;
  import hampel_pkg::*;

  localparam int unsigned TAP_SPACING = 2;
  localparam int unsigned LINE_LEN    = 2 * TAP_SPACING;
  localparam int          HALF_PERIOD = 4;
  localparam int          RESET_CYCLES = 7;
  // Margin for the result path and for items that only fill the line.
  localparam int          SETTLE_CYCLES = 8;
  localparam int          GAP_PERCENT = 22;
  localparam int          MAX_REPORTS = 60;
  localparam int          PHASE_ITEMS = 185;
  localparam int          DIRECTED_ITEMS = 22;

  typedef struct packed {
    sample_t x;
    sample_t y;
    sample_t z;
  } accel_item_t;

  typedef struct packed {
    sample_t fx;
    sample_t fy;
    sample_t fz;
    logic    ox;
    logic    oy;
    logic    oz;
  } filt_result_t;

  // Block ports; the inputs are all known from time zero.
  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_valid_i  = 1'b0;
  logic               cfg_ready_o;
  logic [SCALE_W-1:0] cfg_data_i   = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  sample_t            accel_x_i    = '0;
  sample_t            accel_y_i    = '0;
  sample_t            accel_z_i    = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  sample_t            filtered_x_o;
  sample_t            filtered_y_o;
  sample_t            filtered_z_o;
  logic               outlier_x_o;
  logic               outlier_y_o;
  logic               outlier_z_o;

  // Stimulus and scoreboard storage.
  accel_item_t  pending_samples [$];
  filt_result_t expected_results [$];
  accel_item_t  drive_item;
  int           mismatch_count = 0;
  logic         quiet_mode = 1'b0;

  // Private copy of the filter state.
  sample_t     model_line [AXES][LINE_LEN] = '{default: '0};
  int unsigned model_fill = 0;
  scale_t      model_scale = SCALE_RESET;

  hampel_outlier_filter_3tap #(
    .TAP_SPACING(TAP_SPACING)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .accel_x_i   (accel_x_i),
    .accel_y_i   (accel_y_i),
    .accel_z_i   (accel_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .filtered_x_o(filtered_x_o),
    .filtered_y_o(filtered_y_o),
    .filtered_z_o(filtered_z_o),
    .outlier_x_o (outlier_x_o),
    .outlier_y_o (outlier_y_o),
    .outlier_z_o (outlier_z_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic int median3(input int a, input int b, input int c);
    int lo;
    int hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) return lo;
    if (c >= hi) return hi;
    return c;
  endfunction

  function automatic int abs_gap(input int p, input int q);
    return (p >= q) ? p - q : q - p;
  endfunction

  // Advances the private filter state by one item and queues the result it causes, if any.
  function automatic void hampel_predict(input accel_item_t item);
    sample_t      fresh [AXES];
    sample_t      mid_out [AXES];
    logic         flag [AXES];
    filt_result_t res;
    logic         emit;
    int           a;
    int           b;
    int           c;
    int           med;
    int           mad;
    int           dev;
    emit     = (model_fill >= LINE_LEN);
    fresh[0] = item.x;
    fresh[1] = item.y;
    fresh[2] = item.z;
    for (int ax = 0; ax < AXES; ax++) begin
      c = fresh[ax];
      if (emit) begin
        a   = model_line[ax][0];
        b   = model_line[ax][TAP_SPACING];
        med = median3(a, b, c);
        mad = median3(abs_gap(a, med), abs_gap(b, med), abs_gap(c, med));
        dev = abs_gap(b, med);
        // Strict compare of the scaled deviation, exact in 64 bits.
        flag[ax] = (longint'(dev) * 256) > (longint'(mad) * longint'(model_scale));
        if (flag[ax]) begin
          b = med;
          model_line[ax][TAP_SPACING] = sample_t'(med);
        end
        mid_out[ax] = sample_t'(b);
      end
      for (int k = 0; k + 1 < LINE_LEN; k++) begin
        model_line[ax][k] = model_line[ax][k+1];
      end
      model_line[ax][LINE_LEN-1] = fresh[ax];
    end
    if (model_fill < LINE_LEN) model_fill++;
    if (emit) begin
      res.fx = mid_out[0];
      res.fy = mid_out[1];
      res.fz = mid_out[2];
      res.ox = flag[0];
      res.oy = flag[1];
      res.oz = flag[2];
      expected_results.push_back(res);
    end
  endfunction

  // Random gap decision shared by both channels.
  function automatic logic take_gap();
    return !quiet_mode && ($urandom_range(99) < GAP_PERCENT);
  endfunction

  // Mostly samples near a center with a given spread, plus spikes, full-range
  // values and the extremes.
  function automatic sample_t draw_sample(input int center, input int spread);
    int pick;
    int v;
    pick = $urandom_range(99);
    if (pick < 55) begin
      v = center + int'($urandom_range(2 * spread)) - spread;
    end else if (pick < 70) begin
      v = int'($urandom_range(30000, 200));
      v = $urandom_range(1) ? center + v : center - v;
    end else if (pick < 90) begin
      v = int'($urandom_range(65535)) - 32768;
    end else begin
      case ($urandom_range(3))
        0:       v = -32768;
        1:       v = 32767;
        2:       v = 0;
        default: v = -1;
      endcase
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return sample_t'(v);
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    end
  endtask

  // Writes the threshold scale; called right after a rising edge while idle.
  task automatic write_scale(input scale_t value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    model_scale = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Holds the sender until every queued item is taken and every result has come.
  task automatic drain_and_settle();
    while (pending_samples.size() > 0 || in_valid_i || expected_results.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Item driver: keeps valid and payload steady until the item is taken.
  always @(posedge clk_i or negedge rst_ni) begin : sample_driver
    logic slot_free;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      slot_free = !in_valid_i;
      if (in_valid_i && in_ready_o) begin
        hampel_predict(drive_item);
        slot_free = 1'b1;
      end
      if (slot_free) begin
        if (pending_samples.size() > 0 && !take_gap()) begin
          drive_item = pending_samples.pop_front();
          in_valid_i <= 1'b1;
          accel_x_i  <= drive_item.x;
          accel_y_i  <= drive_item.y;
          accel_z_i  <= drive_item.z;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each taken result against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    filt_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t ns: result with nothing expected, expected none, actual %0d %0d %0d",
                     $time, filtered_x_o, filtered_y_o, filtered_z_o);
          end
        end else begin
          want = expected_results.pop_front();
          check_field("filtered_x", want.fx, filtered_x_o);
          check_field("filtered_y", want.fy, filtered_y_o);
          check_field("filtered_z", want.fz, filtered_z_o);
          check_field("outlier_x", want.ox, outlier_x_o);
          check_field("outlier_y", want.oy, outlier_y_o);
          check_field("outlier_z", want.oz, outlier_z_o);
        end
      end
      out_ready_i <= !take_gap();
    end
  end

  // Test sequence: directed items at the reset scale, then random phases.
  initial begin : stimulus_plan
    int          dir_x [DIRECTED_ITEMS];
    scale_t      phase_scale [7];
    accel_item_t item;
    int          center [AXES];
    int          spread;
    dir_x = '{32767, -32768, 0, -1, 32767, -32768, -32768, 5, 5, 5, 900,
              5, 5, 7, 7, 8, 7, 7, -32768, 32767, -32768, 32767};
    phase_scale = '{16'd0, 16'hFFFF, 16'd256, SCALE_RESET, scale_t'($urandom_range(65535)),
                    scale_t'($urandom_range(1, 600)), 16'd1};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes while filling, a wrap-size jump, a lone spike, a
    // one-count bump over a zero deviation median, and full-scale alternation.
    for (int i = 0; i < DIRECTED_ITEMS; i++) begin
      item.x = sample_t'(dir_x[i]);
      item.y = sample_t'(i * 1000 - 10000);
      item.z = (i == 12) ? sample_t'(-4) : (i == 16) ? sample_t'(32767) : sample_t'(-5);
      pending_samples.push_back(item);
    end
    drain_and_settle();

    // Random phases, each under its own threshold scale.
    for (int p = 0; p < 7; p++) begin
      write_scale(phase_scale[p]);
      quiet_mode = (p == 2);
      spread = $urandom_range(1, 40);
      for (int ax = 0; ax < AXES; ax++) begin
        center[ax] = int'($urandom_range(40000)) - 20000;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        item.x = draw_sample(center[0], spread);
        item.y = draw_sample(center[1], spread);
        item.z = draw_sample(center[2], spread);
        pending_samples.push_back(item);
      end
      drain_and_settle();
    end
    quiet_mode = 1'b0;

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
rtl/hampel_pkg.sv
rtl/hampel_outlier_filter_3tap.sv
bench/tb_hampel_outlier_filter_3tap.sv
